// ----- sv/stereo_volume_mute_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stereo volume controller
// Concurrent checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_VOLUME_MUTE_CONTROLLER_UNIT_MACROS_SVH
`define STEREO_VOLUME_MUTE_CONTROLLER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SVMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SVMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SVMC_ASSERT_NOW(lbl, ante, cons, msg)
`define SVMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/svmc_pkg.sv -----
// ----------------------------------------------------------------------------
// svmc_pkg
// Types, constants and helper functions of the stereo volume controller.
// ----------------------------------------------------------------------------
package svmc_pkg;

    localparam logic [6:0]         LEVEL_MAX    = 7'd100;
    localparam logic [5:0]         ATTEN_MAX    = 6'd63;
    localparam logic [6:0]         STEP_RESET   = 7'd5;
    localparam logic signed [10:0] LEVEL_MAX_W  = 11'sd100;
    localparam logic signed [8:0]  OFFSET_MAX_W = 9'sd100;
    localparam logic signed [8:0]  OFFSET_MIN_W = -9'sd100;
    // floor(level * 63 / 100) == (level * 330309) >> 19 for level 0..100
    localparam logic [25:0]        ATTEN_RECIP  = 26'd330309;

    typedef enum logic [2:0] {
        CMD_SET        = 3'd0,
        CMD_UP         = 3'd1,
        CMD_DOWN       = 3'd2,
        CMD_MUTE       = 3'd3,
        CMD_UNMUTE     = 3'd4,
        CMD_TOGGLE     = 3'd5,
        CMD_SET_OFFSET = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic signed [8:0] left_value;
        logic signed [8:0] right_value;
        logic signed [8:0] offset_value;
    } item_t;

    typedef struct packed {
        logic [6:0]        left_level;
        logic [6:0]        right_level;
        logic [6:0]        base_level;
        logic signed [7:0] offset;
        logic              muted;
        logic              zero_forced;
        logic              mute_line;
    } vol_state_t;

    typedef struct packed {
        logic signed [7:0] applied_offset;
        logic              mute_line;
        logic              user_muted;
        logic [5:0]        right_atten;
        logic [5:0]        left_atten;
        logic [6:0]        right_level;
        logic [6:0]        left_level;
    } result_t;

    function automatic logic [6:0] clamp_level(input logic signed [10:0] v);
        logic [6:0] r;
        if (v < 11'sd0) begin
            r = 7'd0;
        end else if (v > LEVEL_MAX_W) begin
            r = LEVEL_MAX;
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

    function automatic logic [5:0] atten_of(input logic [6:0] level);
        logic [25:0] prod;
        prod = {19'b0, level} * ATTEN_RECIP;
        return ATTEN_MAX - prod[24:19];
    endfunction

endpackage

// ----- sv/svmc_in_reg.sv -----
// ----------------------------------------------------------------------------
// svmc_in_reg
// Input register: captures one command word and holds it until it advances.
// ----------------------------------------------------------------------------
module svmc_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  svmc_pkg::item_t    in_item,
    input  logic               advance,
    output logic               item_valid,
    output svmc_pkg::item_t    item
);

    logic            valid_reg;
    logic            valid_next;
    svmc_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/svmc_core.sv -----
// ----------------------------------------------------------------------------
// svmc_core
// Command decode, level arithmetic, mute logic and attenuation mapping.
// ----------------------------------------------------------------------------
module svmc_core (
    input  svmc_pkg::item_t      item,
    input  logic [6:0]           step_size,
    input  svmc_pkg::vol_state_t state,
    output svmc_pkg::vol_state_t state_next,
    output svmc_pkg::result_t    result
);

    logic signed [10:0] lv_x;
    logic signed [10:0] rv_x;
    logic signed [10:0] la_x;
    logic signed [10:0] ra_x;
    logic signed [10:0] left_x;
    logic signed [10:0] right_x;
    logic signed [10:0] base_x;
    logic signed [10:0] off_x;
    logic signed [7:0]  ov_c;
    logic [6:0]         nv;
    logic signed [10:0] l_raw;
    logic signed [10:0] r_raw;
    logic               apply;
    logic [6:0]         left_n;
    logic [6:0]         right_n;
    logic signed [10:0] left_n_x;

    assign lv_x    = {{2{item.left_value[8]}}, item.left_value};
    assign rv_x    = {{2{item.right_value[8]}}, item.right_value};
    assign la_x    = (item.left_value != 9'sd0) ? lv_x : {4'b0, step_size};
    assign ra_x    = (item.right_value != 9'sd0) ? rv_x : {4'b0, step_size};
    assign left_x  = {4'b0, state.left_level};
    assign right_x = {4'b0, state.right_level};
    assign base_x  = {4'b0, state.base_level};
    assign off_x   = {{3{state.offset[7]}}, state.offset};

    always_comb begin
        priority if (item.offset_value < svmc_pkg::OFFSET_MIN_W) begin
            ov_c = svmc_pkg::OFFSET_MIN_W[7:0];
        end else if (item.offset_value > svmc_pkg::OFFSET_MAX_W) begin
            ov_c = svmc_pkg::OFFSET_MAX_W[7:0];
        end else begin
            ov_c = item.offset_value[7:0];
        end
    end

    assign nv = svmc_pkg::clamp_level(base_x + {{3{ov_c[7]}}, ov_c});

    always_comb begin
        l_raw = left_x;
        r_raw = right_x;
        apply = 1'b0;
        unique case (item.cmd)
            svmc_pkg::CMD_SET: begin
                l_raw = lv_x;
                r_raw = rv_x;
                apply = 1'b1;
            end
            svmc_pkg::CMD_UP: begin
                l_raw = left_x + la_x;
                r_raw = right_x + ra_x;
                apply = 1'b1;
            end
            svmc_pkg::CMD_DOWN: begin
                l_raw = left_x - la_x;
                r_raw = right_x - ra_x;
                apply = 1'b1;
            end
            svmc_pkg::CMD_SET_OFFSET: begin
                l_raw = {4'b0, nv};
                r_raw = {4'b0, nv};
                apply = 1'b1;
            end
            default: begin
                apply = 1'b0;
            end
        endcase
    end

    assign left_n   = svmc_pkg::clamp_level(l_raw);
    assign right_n  = svmc_pkg::clamp_level(r_raw);
    assign left_n_x = {4'b0, left_n};

    always_comb begin
        state_next = state;
        if (apply) begin
            state_next.left_level  = left_n;
            state_next.right_level = right_n;
            state_next.base_level  = (state.offset != 8'sd0)
                                   ? svmc_pkg::clamp_level(left_n_x - off_x) : left_n;
            if (left_n == 7'd0) begin
                state_next.zero_forced = 1'b1;
                state_next.mute_line   = 1'b1;
            end else if (state.zero_forced) begin
                state_next.zero_forced = 1'b0;
                if (!state.muted) begin
                    state_next.mute_line = 1'b0;
                end
            end
        end
        unique case (item.cmd)
            svmc_pkg::CMD_MUTE: begin
                state_next.muted     = 1'b1;
                state_next.mute_line = 1'b1;
            end
            svmc_pkg::CMD_UNMUTE: begin
                state_next.muted     = 1'b0;
                state_next.mute_line = 1'b0;
            end
            svmc_pkg::CMD_TOGGLE: begin
                state_next.muted     = !state.muted;
                state_next.mute_line = !state.muted;
            end
            svmc_pkg::CMD_SET_OFFSET: begin
                state_next.offset = ov_c;
            end
            default: begin
                state_next.offset = state_next.offset;
            end
        endcase
    end

    always_comb begin
        result.left_level     = state_next.left_level;
        result.right_level    = state_next.right_level;
        result.left_atten     = svmc_pkg::atten_of(state_next.left_level);
        result.right_atten    = svmc_pkg::atten_of(state_next.right_level);
        result.user_muted     = state_next.muted;
        result.mute_line      = state_next.mute_line;
        result.applied_offset = state_next.offset;
    end

endmodule

// ----- sv/stereo_volume_mute_controller_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_volume_mute_controller_unit
// Stereo volume controller with user mute, forced mute at zero and offset.
// ----------------------------------------------------------------------------
// Usage:
//   Send one command word per s_ handshake (s_tuser carries the command,
//   s_tdata the left, right and offset values). Every command yields exactly
//   one result word on the m_ channel with both levels, both attenuations,
//   the user mute, the hardware mute line and the applied offset.
//   A word goes from the input handshake into the input register, and from
//   there through the command logic into the result register, which drives
//   m_tvalid. Throughput is one word per cycle while m_tready is high; the
//   state update is a single pass of logic between those two registers, so
//   back-to-back commands see the state left by the previous one.
//   When m_tready is low the result word holds and the input register
//   fills; s_tready drops only once both stages hold a word.
//   cfg_we writes the step size used by up and down when an amount is zero.
//   Reset sets both levels and the base level to 100, the offset to 0, all
//   mute flags clear, the step size to 5, and empties both stages.
// ----------------------------------------------------------------------------
`include "stereo_volume_mute_controller_unit_macros.svh"

module stereo_volume_mute_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_value[8:0], right_value[17:9], offset_value[26:18]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // left_level[6:0], right_level[13:7], left_atten[19:14],
                                   // right_atten[25:20], user_muted[26], mute_line[27],
                                   // applied_offset[35:28]
);

    logic                 advance;
    logic                 item_valid;
    svmc_pkg::item_t      in_item;
    svmc_pkg::item_t      item;
    svmc_pkg::vol_state_t state_reg;
    svmc_pkg::vol_state_t state_next;
    svmc_pkg::result_t    result_next;
    svmc_pkg::result_t    result_reg;
    logic                 out_valid_reg;
    logic [6:0]           step_size_reg;

    assign in_item.cmd          = s_tuser;
    assign in_item.left_value   = s_tdata[8:0];
    assign in_item.right_value  = s_tdata[17:9];
    assign in_item.offset_value = s_tdata[26:18];

    assign advance = item_valid && (!out_valid_reg || m_tready);

    svmc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    svmc_core u_core (
        .item       (item),
        .step_size  (step_size_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= svmc_pkg::STEP_RESET;
        end else if (cfg_we) begin
            step_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.left_level  <= svmc_pkg::LEVEL_MAX;
            state_reg.right_level <= svmc_pkg::LEVEL_MAX;
            state_reg.base_level  <= svmc_pkg::LEVEL_MAX;
            state_reg.offset      <= 8'sd0;
            state_reg.muted       <= 1'b0;
            state_reg.zero_forced <= 1'b0;
            state_reg.mute_line   <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, result_reg};

    `SVMC_ASSERT_NOW(a_level_range, 1'b1,
        state_reg.left_level <= svmc_pkg::LEVEL_MAX && state_reg.right_level <= svmc_pkg::LEVEL_MAX,
        "level out of range")
    `SVMC_ASSERT_NOW(a_muted_drives_line, state_reg.muted, state_reg.mute_line,
        "user mute active without mute line")
    `SVMC_ASSERT_NOW(a_zero_forces, state_reg.left_level == 7'd0, state_reg.zero_forced,
        "zero left level without forced mute flag")
    `SVMC_ASSERT_NEXT(a_result_follows, advance, m_tvalid,
        "result missing after advance")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo volume controller: drives command words
// with random gaps and sink stalls, tracks levels, offset and mute state in a
// local model, and compares every status word field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] CMD_NOP = 3'd7;
    localparam int LVL_TOP = 100;
    localparam int ATT_TOP = 63;
    localparam int OFS_LIM = 100;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // left_value[8:0], right_value[17:9], offset_value[26:18]
    logic [2:0]  s_tuser   = '0;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // left_level, right_level, left_atten, right_atten,
                                   // user_muted, mute_line, applied_offset

    int                lvl_l;
    int                lvl_r;
    int                base_lvl;
    int                offs;
    int                step_amt;
    bit                muted;
    bit                zero_forced;
    bit                mute_drv;
    svmc_pkg::result_t status_due[$];
    int                bad_cnt       = 0;
    int                src_idle_pct  = 30;
    int                sink_idle_pct = 30;
    int                stall_req     = 0;
    int                stall_left    = 0;

    stereo_volume_mute_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic int clamp_lvl(int v);
        if (v < 0) begin
            return 0;
        end else if (v > LVL_TOP) begin
            return LVL_TOP;
        end
        return v;
    endfunction

    function automatic void reset_volume();
        lvl_l       = LVL_TOP;
        lvl_r       = LVL_TOP;
        base_lvl    = LVL_TOP;
        offs        = 0;
        step_amt    = int'(svmc_pkg::STEP_RESET);
        muted       = 1'b0;
        zero_forced = 1'b0;
        mute_drv    = 1'b0;
    endfunction

    function automatic void set_levels(int l, int r);
        lvl_l    = clamp_lvl(l);
        lvl_r    = clamp_lvl(r);
        base_lvl = (offs != 0) ? clamp_lvl(lvl_l - offs) : lvl_l;
        if (lvl_l == 0) begin
            zero_forced = 1'b1;
            mute_drv    = 1'b1;
        end else if (zero_forced) begin
            zero_forced = 1'b0;
            if (!muted) begin
                mute_drv = 1'b0;
            end
        end
    endfunction

    function automatic svmc_pkg::result_t advance_volume(logic [2:0] cmd,
                                                         logic signed [8:0] lv,
                                                         logic signed [8:0] rv,
                                                         logic signed [8:0] ov);
        int                la;
        int                ra;
        int                o;
        int                nv;
        int                att_l;
        int                att_r;
        svmc_pkg::result_t st;
        la = (lv != 0) ? int'(lv) : step_amt;
        ra = (rv != 0) ? int'(rv) : step_amt;
        case (cmd)
            svmc_pkg::CMD_SET: begin
                set_levels(int'(lv), int'(rv));
            end
            svmc_pkg::CMD_UP: begin
                set_levels(lvl_l + la, lvl_r + ra);
            end
            svmc_pkg::CMD_DOWN: begin
                set_levels(lvl_l - la, lvl_r - ra);
            end
            svmc_pkg::CMD_MUTE: begin
                muted    = 1'b1;
                mute_drv = 1'b1;
            end
            svmc_pkg::CMD_UNMUTE: begin
                muted    = 1'b0;
                mute_drv = 1'b0;
            end
            svmc_pkg::CMD_TOGGLE: begin
                muted    = !muted;
                mute_drv = muted;
            end
            svmc_pkg::CMD_SET_OFFSET: begin
                o = int'(ov);
                if (o < -OFS_LIM) begin
                    o = -OFS_LIM;
                end else if (o > OFS_LIM) begin
                    o = OFS_LIM;
                end
                nv = clamp_lvl(base_lvl + o);
                set_levels(nv, nv);
                offs = o;
            end
            default: begin
            end
        endcase
        att_l             = ATT_TOP - lvl_l * ATT_TOP / LVL_TOP;
        att_r             = ATT_TOP - lvl_r * ATT_TOP / LVL_TOP;
        st.left_level     = lvl_l[6:0];
        st.right_level    = lvl_r[6:0];
        st.left_atten     = att_l[5:0];
        st.right_atten    = att_r[5:0];
        st.user_muted     = muted;
        st.mute_line      = mute_drv;
        st.applied_offset = offs[7:0];
        return st;
    endfunction

    // status checker
    always @(posedge aclk) begin
        svmc_pkg::result_t got;
        svmc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[35:0];
            if (status_due.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= 10) begin
                    $display("status word with none pending: %h", m_tdata);
                end
            end else begin
                want = status_due.pop_front();
                if (got.left_level !== want.left_level
                        || got.right_level !== want.right_level
                        || got.left_atten !== want.left_atten
                        || got.right_atten !== want.right_atten
                        || got.user_muted !== want.user_muted
                        || got.mute_line !== want.mute_line
                        || got.applied_offset !== want.applied_offset) begin
                    bad_cnt++;
                    if (bad_cnt <= 10) begin
                        $display({"status mismatch at %0t: lvl %0d/%0d att %0d/%0d",
                                  " mute %0b line %0b ofs %0d"},
                                 $realtime, want.left_level, want.right_level,
                                 want.left_atten, want.right_atten, want.user_muted,
                                 want.mute_line, want.applied_offset);
                        $display({"                    got: lvl %0d/%0d att %0d/%0d",
                                  " mute %0b line %0b ofs %0d"},
                                 got.left_level, got.right_level, got.left_atten,
                                 got.right_atten, got.user_muted, got.mute_line,
                                 got.applied_offset);
                    end
                end
            end
        end
    end

    // sink: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req  = 0;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_word(logic [2:0] cmd, logic signed [8:0] lv, logic signed [8:0] rv,
                             logic signed [8:0] ov);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, ov, rv, lv};
        do @(posedge aclk); while (!s_tready);
        status_due.push_back(advance_volume(cmd, lv, rv, ov));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_step(logic [6:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        step_amt = int'(v);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [8:0] pick_value();
        int k;
        k = $urandom_range(9);
        case (k)
            0: return 9'sd0;
            1, 2, 3, 4: return 9'($urandom_range(100));
            5, 6: return 9'(int'($urandom_range(40)) - 20);
            7: return $urandom_range(1) ? 9'sd255 : -9'sd256;
            default: return 9'($urandom);
        endcase
    endfunction

    task automatic send_random_word();
        int          r;
        logic [2:0]  cmd;
        r = $urandom_range(99);
        if (r < 25) begin
            cmd = svmc_pkg::CMD_SET;
        end else if (r < 40) begin
            cmd = svmc_pkg::CMD_UP;
        end else if (r < 55) begin
            cmd = svmc_pkg::CMD_DOWN;
        end else if (r < 62) begin
            cmd = svmc_pkg::CMD_MUTE;
        end else if (r < 69) begin
            cmd = svmc_pkg::CMD_UNMUTE;
        end else if (r < 78) begin
            cmd = svmc_pkg::CMD_TOGGLE;
        end else if (r < 97) begin
            cmd = svmc_pkg::CMD_SET_OFFSET;
        end else begin
            cmd = CMD_NOP;
        end
        send_word(cmd, pick_value(), pick_value(), pick_value());
    endtask

    task automatic test_directed();
        send_word(svmc_pkg::CMD_SET, 9'sd100, 9'sd100, 9'sd0);
        send_word(svmc_pkg::CMD_SET, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_UP, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_SET, -9'sd256, 9'sd255, 9'sd0);
        send_word(svmc_pkg::CMD_SET, 9'sd255, -9'sd256, -9'sd1);
        send_word(svmc_pkg::CMD_DOWN, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_MUTE, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_SET, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_UP, 9'sd10, 9'sd10, 9'sd0);
        send_word(svmc_pkg::CMD_UNMUTE, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_SET, 9'sd0, 9'sd50, 9'sd0);
        send_word(svmc_pkg::CMD_UNMUTE, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_TOGGLE, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_TOGGLE, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_SET, 9'sd50, 9'sd60, 9'sd0);
        send_word(svmc_pkg::CMD_SET_OFFSET, 9'sd0, 9'sd0, 9'sd255);
        send_word(svmc_pkg::CMD_SET_OFFSET, 9'sd0, 9'sd0, -9'sd256);
        send_word(svmc_pkg::CMD_SET_OFFSET, 9'sd0, 9'sd0, 9'sd37);
        send_word(svmc_pkg::CMD_SET_OFFSET, 9'sd0, 9'sd0, 9'sd0);
        send_word(svmc_pkg::CMD_UP, 9'sd255, 9'sd255, 9'sd0);
        send_word(svmc_pkg::CMD_DOWN, -9'sd256, -9'sd256, 9'sd0);
        send_word(svmc_pkg::CMD_UP, -9'sd256, 9'sd1, 9'sd0);
        send_word(CMD_NOP, 9'sd255, -9'sd1, -9'sd256);
        send_word(svmc_pkg::CMD_SET_OFFSET, -9'sd1, -9'sd1, -9'sd30);
        drain();
    endtask

    task automatic test_step_size();
        logic [6:0] steps [5];
        steps = '{7'd0, 7'd100, 7'd1, 7'd99, 7'd37};
        foreach (steps[i]) begin
            write_step(steps[i]);
            send_word(svmc_pkg::CMD_SET, 9'sd50, 9'sd20, 9'sd0);
            send_word(svmc_pkg::CMD_UP, 9'sd0, 9'sd0, 9'sd0);
            send_word(svmc_pkg::CMD_DOWN, 9'sd0, 9'sd0, 9'sd0);
            send_word(svmc_pkg::CMD_DOWN, 9'sd0, 9'sd3, 9'sd0);
            drain();
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        stall_req    = 120;
        repeat (40) send_random_word();
        src_idle_pct = 30;
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 350 == 349) begin
                drain();
                write_step(7'($urandom_range(100)));
            end
            if (i >= 400 && i < 700) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 30;
                sink_idle_pct = 30;
            end
            send_random_word();
        end
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        drain();
    endtask

    initial begin
        reset_volume();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_step_size();
        test_backpressure();
        test_random(1400);
        repeat (20) @(posedge aclk);
        if (bad_cnt == 0 && status_due.size() == 0) begin
            $display("[stereo_volume_mute_controller_unit] OK");
        end else begin
            $display("[stereo_volume_mute_controller_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[stereo_volume_mute_controller_unit] ERROR");
        $finish;
    end

endmodule
